// ===== src/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg: shared types, constants and fixed-point helpers
// Q4.FRAC_BITS number format, saturating add/subtract, product rounding,
// configuration register indexes and controller command codes.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Number format
  localparam int FRAC_BITS = 28;
  localparam int QW        = FRAC_BITS + 4;       // Q4.FRAC_BITS word
  localparam int PROD_W    = 2 * QW;              // full signed product
  localparam int FIX_W     = PROD_W - FRAC_BITS;  // product after the binary-point shift

  typedef logic signed [QW-1:0]     q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q_t QMAX = q_t'({1'b0, {(QW-1){1'b1}}});
  localparam q_t QMIN = q_t'({1'b1, {(QW-1){1'b0}}});

  localparam q_t C_TWO_HALF = q_t'(64'd5 << (FRAC_BITS - 1));  // 2.5
  localparam q_t C_ONE_QTR  = q_t'(64'd5 << (FRAC_BITS - 2));  // 1.25
  localparam q_t C_FOUR     = q_t'(64'd4 << FRAC_BITS);        // 4.0

  // Iteration limit default
  localparam int MAX_ITER_DEF = 1500;

  // Field and register widths
  localparam int PIX_W      = 12;
  localparam int WID_W      = 13;
  localparam int SCALE_W    = 31;
  localparam int OFF_W      = 21;
  localparam int COL_W      = 8;
  localparam int IN_W       = 2 * PIX_W;
  localparam int OUT_W      = 3 * COL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Coordinate mapping widths
  localparam int SUM_W     = OFF_W + 1;     // pixel plus offset, signed
  localparam int MAG_W     = OFF_W;         // magnitude of that sum
  localparam int NUM_W     = MAG_W + 3;     // magnitude times 4 or 5
  localparam int REM_W     = NUM_W + 1;     // divider remainder
  localparam int DEN_W     = WID_W + 4;     // divisor scaled by 8 or 16
  localparam int QUO_W     = QW - 1;        // 3 integer + FRAC_BITS fraction bits
  localparam int DIV_STEPS = QUO_W;

  // Shade divider (255 / steps)
  localparam int RDIV_STEPS = COL_W;

  localparam logic [COL_W-1:0] COL_MAX  = '1;
  localparam logic [COL_W-1:0] COL_ZERO = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFY   = 3'd4;

  // Configuration reset values
  localparam logic [WID_W-1:0]   WIDTH_RST  = 13'd1920;
  localparam logic [WID_W-1:0]   HEIGHT_RST = 13'd1200;
  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(64'd1 << FRAC_BITS);
  localparam logic [OFF_W-1:0]   OFF_RST    = '0;

  // Controller to datapath command
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,   // capture pixel plus offset
    OP_PREP,   // magnitudes, numerators, divisors
    OP_CHK,    // integer part overflow check
    OP_DIV,    // one quotient bit per lane
    OP_RSIGN,  // apply sign / saturation to the ratio
    OP_RSUB,   // subtract the axis constant
    OP_MMUL,   // multiply by zoom scale
    OP_MFIX,   // round scaled point, clear z
    OP_IMUL,   // zr*zr, zi*zi, zr*zi
    OP_IFIX,   // round the three products
    OP_IUPD,   // escape test and z update
    OP_RDIV,   // one bit of the shade divide
    OP_OUT     // load the result register
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic esc;       // |z|^2 >= 4 in the update cycle
    logic at_max;    // step count at its limit
    logic out_free;  // result register can take a new item
  } stat_t;

  // Saturating add
  function automatic q_t q_add(input q_t a, input q_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? QMIN : QMAX;
    end
    return q_t'(s[QW-1:0]);
  endfunction

  // Saturating subtract
  function automatic q_t q_sub(input q_t a, input q_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? QMIN : QMAX;
    end
    return q_t'(s[QW-1:0]);
  endfunction

  // Product back to Q format: truncate toward zero, then saturate
  function automatic q_t q_fix(input prod_t p);
    logic [FIX_W-1:0] t;
    logic             inc;
    inc = p[PROD_W-1] & (|p[FRAC_BITS-1:0]);
    t   = p[PROD_W-1:FRAC_BITS] + FIX_W'(inc);
    if (t[FIX_W-1:QW-1] == {(FIX_W-QW+1){t[FIX_W-1]}}) begin
      return q_t'(t[QW-1:0]);
    end
    return t[FIX_W-1] ? QMIN : QMAX;
  endfunction

endpackage

// ===== src/mandelbrot_escape_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top: escape-time pixel shader
// Maps a pixel to a point c of the complex plane, iterates z = z^2 + c in
// Q4.28 saturating fixed point and returns the escape shade as RGB.
//
// One item at a time: in_tready is high only while the block is idle, and a
// finished result sits in the output register so the next pixel can be taken
// while it waits. Each escape step is one pass through the three shared
// multipliers, a product rounding step and an update step. Mapping uses a
// bit-serial ratio divide, and the red shade a bit-serial divide of its own.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top #(
  parameter int MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: pixel_x [11:0], pixel_y [23:12]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mep_pkg::IN_W-1:0]        in_tdata,
  // out_tdata: red [7:0], green [15:8], blue [23:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mep_pkg::OUT_W-1:0]       out_tdata,
  // index 0 width, 1 height, 2 zoom scale, 3 offset x, 4 offset y
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mep_pkg::op_t   cmd;
  mep_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  // Sequencer
  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  // Arithmetic and result register
  mep_dpath #(
    .MAX_ITER (MAX_ITER)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/mep_ctrl.sv =====
// ----------------------------------------------------------------------------
// mep_ctrl: pixel sequencer
// Walks one item through mapping, the escape loop, the shade divide and the
// result register, one datapath command per cycle unless idle or stalled.
// ----------------------------------------------------------------------------
module mep_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output mep_pkg::op_t    cmd,
  input  mep_pkg::stat_t  st
);

  localparam int CNT_W = $clog2(mep_pkg::DIV_STEPS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_RSIGN = 4'd4;
  localparam logic [3:0] S_RSUB  = 4'd5;
  localparam logic [3:0] S_MMUL  = 4'd6;
  localparam logic [3:0] S_MFIX  = 4'd7;
  localparam logic [3:0] S_IMUL  = 4'd8;
  localparam logic [3:0] S_IFIX  = 4'd9;
  localparam logic [3:0] S_IUPD  = 4'd10;
  localparam logic [3:0] S_RDIV  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = mep_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = mep_pkg::OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd       = mep_pkg::OP_PREP;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd       = mep_pkg::OP_CHK;
        cnt_nxt   = CNT_W'(mep_pkg::DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd = mep_pkg::OP_DIV;
        if (cnt_r == '0) begin
          state_nxt = S_RSIGN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RSIGN: begin
        cmd       = mep_pkg::OP_RSIGN;
        state_nxt = S_RSUB;
      end
      S_RSUB: begin
        cmd       = mep_pkg::OP_RSUB;
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        cmd       = mep_pkg::OP_MMUL;
        state_nxt = S_MFIX;
      end
      S_MFIX: begin
        cmd       = mep_pkg::OP_MFIX;
        state_nxt = S_IMUL;
      end
      S_IMUL: begin
        cmd       = mep_pkg::OP_IMUL;
        state_nxt = S_IFIX;
      end
      S_IFIX: begin
        cmd       = mep_pkg::OP_IFIX;
        state_nxt = S_IUPD;
      end
      S_IUPD: begin
        cmd = mep_pkg::OP_IUPD;
        if (st.esc) begin
          cnt_nxt   = CNT_W'(mep_pkg::RDIV_STEPS - 1);
          state_nxt = S_RDIV;
        end else if (st.at_max) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IMUL;
        end
      end
      S_RDIV: begin
        cmd = mep_pkg::OP_RDIV;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd       = mep_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== src/mep_dpath.sv =====
// ----------------------------------------------------------------------------
// mep_dpath: mapping, escape-loop and shade datapath
// Holds the configuration registers, a two-lane bit-serial ratio divider,
// three shared 32x32 multipliers, the z registers and step counter, the
// shade divider and the result register.
// ----------------------------------------------------------------------------
module mep_dpath #(
  parameter int MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [mep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [mep_pkg::IN_W-1:0]         in_tdata,
  input  mep_pkg::op_t                     cmd,
  output mep_pkg::stat_t                   st,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mep_pkg::OUT_W-1:0]        out_tdata
);

  localparam int ITW = $clog2(MAX_ITER + 1);

  // Configuration registers
  logic [mep_pkg::WID_W-1:0]   width_r, height_r;
  logic [mep_pkg::SCALE_W-1:0] scale_r;
  logic [mep_pkg::OFF_W-1:0]   offx_r, offy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mep_pkg::WIDTH_RST;
      height_r <= mep_pkg::HEIGHT_RST;
      scale_r  <= mep_pkg::SCALE_RST;
      offx_r   <= mep_pkg::OFF_RST;
      offy_r   <= mep_pkg::OFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mep_pkg::REG_WIDTH:  width_r  <= cfg_data[mep_pkg::WID_W-1:0];
        mep_pkg::REG_HEIGHT: height_r <= cfg_data[mep_pkg::WID_W-1:0];
        mep_pkg::REG_SCALE:  scale_r  <= cfg_data[mep_pkg::SCALE_W-1:0];
        mep_pkg::REG_OFFX:   offx_r   <= cfg_data[mep_pkg::OFF_W-1:0];
        mep_pkg::REG_OFFY:   offy_r   <= cfg_data[mep_pkg::OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  logic [mep_pkg::SUM_W-1:0] sum_r [2];
  logic                      neg_r [2];
  logic                      sat_r [2];
  logic [mep_pkg::REM_W-1:0] rem_r [2];
  logic [mep_pkg::DEN_W-1:0] den_r [2];
  logic [mep_pkg::QUO_W-1:0] quo_r [2];
  mep_pkg::q_t               c_r   [2];   // ratio, then scaled point
  mep_pkg::prod_t            p_r   [3];
  mep_pkg::q_t               f_r   [3];   // rr, ii, ri
  mep_pkg::q_t               zr_r, zi_r;
  logic [ITW-1:0]            iter_r;
  logic                      esc_r;
  logic [mep_pkg::COL_W-1:0] rd_rem_r, rd_q_r, rd_den_r;
  logic                      rd_big_r;
  logic                      out_valid_r;
  logic [mep_pkg::OUT_W-1:0] out_data_r;

  // Pixel fields, lowest first
  logic [mep_pkg::PIX_W-1:0] pix [2];
  logic [mep_pkg::OFF_W-1:0] off [2];
  assign pix[0] = in_tdata[mep_pkg::PIX_W-1:0];
  assign pix[1] = in_tdata[mep_pkg::IN_W-1:mep_pkg::PIX_W];
  assign off[0] = offx_r;
  assign off[1] = offy_r;

  // Divisors: width*8 for real, height*16 (2*height*8) for imaginary
  logic [mep_pkg::WID_W-1:0] w1, h1;
  assign w1 = (width_r == '0) ? mep_pkg::WID_W'(1) : width_r;
  assign h1 = (height_r == '0) ? mep_pkg::WID_W'(1) : height_r;

  // Ratio lanes: magnitude, numerator, one restoring step
  logic [mep_pkg::SUM_W-1:0] sum_nxt [2];
  logic [mep_pkg::MAG_W-1:0] mag_w   [2];
  logic [mep_pkg::NUM_W-1:0] num_w   [2];
  logic [mep_pkg::REM_W:0]   r2      [2];
  logic [mep_pkg::REM_W:0]   rdiff   [2];
  logic                      ge      [2];
  mep_pkg::q_t               qmag    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum_nxt[l] = {{(mep_pkg::SUM_W-mep_pkg::PIX_W){1'b0}}, pix[l]}
                 + {{(mep_pkg::SUM_W-mep_pkg::OFF_W){off[l][mep_pkg::OFF_W-1]}}, off[l]};
      mag_w[l]   = sum_r[l][mep_pkg::SUM_W-1] ? mep_pkg::MAG_W'(-sum_r[l])
                                              : mep_pkg::MAG_W'(sum_r[l]);
      r2[l]      = {rem_r[l], 1'b0};
      rdiff[l]   = r2[l] - (mep_pkg::REM_W+1)'(den_r[l]);
      ge[l]      = r2[l] >= (mep_pkg::REM_W+1)'(den_r[l]);
      qmag[l]    = mep_pkg::q_t'({1'b0, quo_r[l]});
    end
    num_w[0] = mep_pkg::NUM_W'(mag_w[0]) << 2;
    num_w[1] = (mep_pkg::NUM_W'(mag_w[1]) << 2) + mep_pkg::NUM_W'(mag_w[1]);
  end

  // Multiplier operand select: scaling or z products
  mep_pkg::q_t scale_q;
  mep_pkg::q_t ma [3];
  mep_pkg::q_t mb [3];
  assign scale_q = mep_pkg::q_t'({1'b0, scale_r});

  always_comb begin
    if (cmd == mep_pkg::OP_MMUL) begin
      ma[0] = c_r[0];  mb[0] = scale_q;
      ma[1] = c_r[1];  mb[1] = scale_q;
      ma[2] = c_r[0];  mb[2] = c_r[1];
    end else begin
      ma[0] = zr_r;    mb[0] = zr_r;
      ma[1] = zi_r;    mb[1] = zi_r;
      ma[2] = zr_r;    mb[2] = zi_r;
    end
  end

  // Escape test and next z
  mep_pkg::q_t mag_sum, zr_nxt, zi_nxt;
  logic        esc_w;
  assign mag_sum = mep_pkg::q_add(f_r[0], f_r[1]);
  assign esc_w   = mag_sum >= mep_pkg::C_FOUR;
  assign zi_nxt  = mep_pkg::q_add(mep_pkg::q_add(f_r[2], f_r[2]), c_r[1]);
  assign zr_nxt  = mep_pkg::q_add(mep_pkg::q_sub(f_r[0], f_r[1]), c_r[0]);

  // Shade divider step: 255 / steps, numerator bits are all ones
  logic [15:0]                 iter16;
  logic [mep_pkg::COL_W:0]     rd_r2, rd_diff;
  logic                        rd_ge;
  logic [mep_pkg::COL_W-1:0]   red_w;
  assign iter16  = 16'(iter_r);
  assign rd_r2   = {rd_rem_r, 1'b1};
  assign rd_diff = rd_r2 - {1'b0, rd_den_r};
  assign rd_ge   = rd_r2 >= {1'b0, rd_den_r};
  assign red_w   = rd_big_r ? mep_pkg::COL_MAX : (mep_pkg::COL_MAX - rd_q_r);

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      mep_pkg::OP_LOAD: begin
        for (int l = 0; l < 2; l++) begin
          sum_r[l] <= sum_nxt[l];
        end
      end
      mep_pkg::OP_PREP: begin
        for (int l = 0; l < 2; l++) begin
          neg_r[l] <= sum_r[l][mep_pkg::SUM_W-1];
          rem_r[l] <= mep_pkg::REM_W'(num_w[l]);
        end
        den_r[0] <= mep_pkg::DEN_W'(w1) << 3;
        den_r[1] <= mep_pkg::DEN_W'(h1) << 4;
      end
      mep_pkg::OP_CHK: begin
        for (int l = 0; l < 2; l++) begin
          sat_r[l] <= rem_r[l] >= mep_pkg::REM_W'(den_r[l]);
        end
      end
      mep_pkg::OP_DIV: begin
        for (int l = 0; l < 2; l++) begin
          rem_r[l] <= ge[l] ? rdiff[l][mep_pkg::REM_W-1:0] : r2[l][mep_pkg::REM_W-1:0];
          quo_r[l] <= {quo_r[l][mep_pkg::QUO_W-2:0], ge[l]};
        end
      end
      mep_pkg::OP_RSIGN: begin
        for (int l = 0; l < 2; l++) begin
          if (sat_r[l]) begin
            c_r[l] <= neg_r[l] ? mep_pkg::QMIN : mep_pkg::QMAX;
          end else begin
            c_r[l] <= neg_r[l] ? -qmag[l] : qmag[l];
          end
        end
      end
      mep_pkg::OP_RSUB: begin
        c_r[0] <= mep_pkg::q_sub(c_r[0], mep_pkg::C_TWO_HALF);
        c_r[1] <= mep_pkg::q_sub(c_r[1], mep_pkg::C_ONE_QTR);
      end
      mep_pkg::OP_MMUL, mep_pkg::OP_IMUL: begin
        for (int k = 0; k < 3; k++) begin
          p_r[k] <= ma[k] * mb[k];
        end
      end
      mep_pkg::OP_MFIX: begin
        c_r[0] <= mep_pkg::q_fix(p_r[0]);
        c_r[1] <= mep_pkg::q_fix(p_r[1]);
        zr_r   <= '0;
        zi_r   <= '0;
      end
      mep_pkg::OP_IFIX: begin
        for (int k = 0; k < 3; k++) begin
          f_r[k] <= mep_pkg::q_fix(p_r[k]);
        end
      end
      mep_pkg::OP_IUPD: begin
        if (esc_w) begin
          esc_r    <= 1'b1;
          rd_rem_r <= '0;
          rd_q_r   <= '0;
          rd_den_r <= iter16[mep_pkg::COL_W-1:0];
          rd_big_r <= iter16 > 16'd255;
        end else if (st.at_max) begin
          esc_r <= 1'b0;
        end else begin
          zr_r <= zr_nxt;
          zi_r <= zi_nxt;
        end
      end
      mep_pkg::OP_RDIV: begin
        rd_rem_r <= rd_ge ? rd_diff[mep_pkg::COL_W-1:0] : rd_r2[mep_pkg::COL_W-1:0];
        rd_q_r   <= {rd_q_r[mep_pkg::COL_W-2:0], rd_ge};
      end
      mep_pkg::OP_OUT: begin
        out_data_r <= esc_r ? {mep_pkg::COL_ZERO, mep_pkg::COL_ZERO, red_w}
                            : {mep_pkg::COL_MAX, mep_pkg::COL_MAX, mep_pkg::COL_MAX};
      end
      default: begin
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd == mep_pkg::OP_MFIX) begin
      iter_r <= '0;
    end else if (cmd == mep_pkg::OP_IUPD && !esc_w && !st.at_max) begin
      iter_r <= iter_r + 1'b1;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == mep_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Status
  assign st.esc      = esc_w;
  assign st.at_max   = (iter_r == ITW'(MAX_ITER));
  assign st.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mep_pkg::OP_OUT) |-> (!out_valid_r || out_tready))
    else $error("result register loaded while a result is pending");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= ITW'(MAX_ITER))
    else $error("step count above its limit");

  a_esc_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mep_pkg::OP_IUPD && esc_w) |-> (iter_r != '0))
    else $error("escape flagged before any step");

endmodule
